FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_LIMIT  = 6'd56;

   typedef enum logic [3:0] {
      ST_IDLE,     // take a request
      ST_WRITE,    // write the merged block word back
      ST_LOAD,     // copy chain words into round variables
      ST_ROUND,    // one compression round per cycle
      ST_ADD,      // add round variables into chain words
      ST_CLEAR,    // zero the block store
      ST_PAD,      // write the pad byte
      ST_LEN,      // write the bit length
      ST_OUT,      // deliver digest words
      ST_INIT      // restore initial chain words
   } state_type;

   typedef enum logic [1:0] {
      NX_DONE,     // back to idle
      NX_PAD,      // padding still to add
      NX_LEN,      // length block still to compress
      NX_OUT       // digest ready
   } after_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for request bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;
   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_index;
   logic [31:0] digest_word;
   logic        last_word;
   modport source (output valid, word_index, digest_word, last_word, input ready);
   modport sink   (input valid, word_index, digest_word, last_word, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// A byte is taken with a block word read, then the merged word is written back;
// a full block then runs chain load, compression rounds, chain add and block clear.
// Block words come from memory; the schedule window is a 16-word shift register.
// A last request adds pad and length writes, one or two block compressions,
// then 8 digest words, each read and then held until the receiver takes it.
// Reset (and each digest) reloads the chain words, then clears the block store.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher (
   input  wire logic       clock,
   input  wire logic       reset,
   sha256_req_if.sink      req,
   sha256_rsp_if.source    rsp
);

   // block store / message schedule: 16 words, one read and one write port, registered read
   logic [31:0] blk_mem [16];
   logic [31:0] blk_rd_ff;
   logic [3:0]  blk_ra, blk_wa;
   logic        blk_we;
   logic [31:0] blk_wd;

   // chain words: 8 words, one read and one write port, registered read
   logic [31:0] chn_mem [8];
   logic [31:0] chn_rd_ff;
   logic [2:0]  chn_ra, chn_wa;
   logic        chn_we;
   logic [31:0] chn_wd;

   always_ff @(posedge clock) begin
      if (blk_we) blk_mem[blk_wa] <= blk_wd;
      blk_rd_ff <= blk_mem[blk_ra];
      if (chn_we) chn_mem[chn_wa] <= chn_wd;
      chn_rd_ff <= chn_mem[chn_ra];
   end

   sha256_pkg::state_type state_ff, state_in;
   sha256_pkg::after_type after_ff, after_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] bytes_ff, bytes_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];   // rolling schedule window
   logic [31:0] w_in [16];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] wt, t1, t2, s0, s1, wnew, merged;
   logic [1:0]  bsel;

   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      // first 16 rounds take words straight from memory
      wt = (cnt_ff < 7'd16) ? blk_rd_ff : wnew;
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::ROUND_K[cnt_ff[5:0]] + wt;
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      bsel = fill_ff[1:0];
      merged = blk_rd_ff;
      case (bsel)
         2'd0: merged[31:24] = byte_ff;
         2'd1: merged[23:16] = byte_ff;
         2'd2: merged[15:8]  = byte_ff;
         default: merged[7:0] = byte_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      blk_ra = fill_ff[5:2];
      blk_wa = fill_ff[5:2];
      blk_we = 1'b0;
      blk_wd = merged;
      chn_ra = cnt_ff[2:0];
      chn_wa = cnt_ff[2:0];
      chn_we = 1'b0;
      chn_wd = 32'd0;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      rsp.word_index  = cnt_ff[3:1];
      rsp.digest_word = chn_rd_ff;
      rsp.last_word   = (cnt_ff[3:1] == 3'd7);
      unique case (state_ff)
         sha256_pkg::ST_INIT: begin
            chn_we = 1'b1;
            chn_wd = sha256_pkg::INIT_HASH[cnt_ff[2:0]];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd7) begin
               cnt_in = 7'd0;
               fill_in = 6'd0;
               bytes_in = 61'd0;
               state_in = sha256_pkg::ST_CLEAR;
               after_in = sha256_pkg::NX_DONE;
            end
         end
         sha256_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               byte_in = req.data_byte;
               last_in = req.last;
               if (req.byte_valid) begin
                  state_in = sha256_pkg::ST_WRITE;
                  bytes_in = bytes_ff + 61'd1;
               end else if (req.last) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_WRITE: begin
            blk_we = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = sha256_pkg::ST_LOAD;
               after_in = last_ff ? sha256_pkg::NX_PAD : sha256_pkg::NX_DONE;
            end else if (last_ff) begin
               state_in = sha256_pkg::ST_PAD;
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_PAD: begin
            // first pass issues the pad word read; second pass merges in the pad byte
            blk_ra = fill_ff[5:2];
            if (cnt_ff == 7'd0) begin
               cnt_in = 7'd1;
            end else begin
               cnt_in = 7'd0;
               blk_we = 1'b1;
               case (bsel)
                  2'd0: blk_wd = {sha256_pkg::PAD_BYTE, blk_rd_ff[23:0]};
                  2'd1: blk_wd = {blk_rd_ff[31:24], sha256_pkg::PAD_BYTE, blk_rd_ff[15:0]};
                  2'd2: blk_wd = {blk_rd_ff[31:16], sha256_pkg::PAD_BYTE, blk_rd_ff[7:0]};
                  default: blk_wd = {blk_rd_ff[31:8], sha256_pkg::PAD_BYTE};
               endcase
               fill_in = fill_ff + 6'd1;
               if (fill_ff == 6'd63 || fill_ff >= sha256_pkg::LEN_LIMIT) begin
                  state_in = sha256_pkg::ST_LOAD;
                  after_in = sha256_pkg::NX_LEN;
               end else begin
                  state_in = sha256_pkg::ST_LEN;
               end
            end
         end
         sha256_pkg::ST_LEN: begin
            blk_we = 1'b1;
            if (cnt_ff == 7'd0) begin
               blk_wa = 4'd14;
               blk_wd = {bytes_ff[60:29]};
               cnt_in = 7'd1;
            end else begin
               blk_wa = 4'd15;
               blk_wd = {bytes_ff[28:0], 3'b000};
               cnt_in = 7'd0;
               state_in = sha256_pkg::ST_LOAD;
               after_in = sha256_pkg::NX_OUT;
            end
         end
         sha256_pkg::ST_LOAD: begin
            // cnt 0..8: read chain word cnt, capture previous one
            chn_ra = cnt_ff[2:0];
            blk_ra = 4'd0;
            if (cnt_ff != 7'd0) v_in[cnt_ff[2:0] - 3'd1] = chn_rd_ff;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd8) begin
               cnt_in = 7'd0;
               state_in = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            blk_ra = 4'(cnt_ff + 7'd1);
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = wt;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in = 7'd0;
               state_in = sha256_pkg::ST_ADD;
            end
         end
         sha256_pkg::ST_ADD: begin
            // even cnt: read word; odd cnt: write sum back
            chn_ra = cnt_ff[3:1];
            chn_wa = cnt_ff[3:1];
            chn_wd = chn_rd_ff + v_ff[cnt_ff[3:1]];
            chn_we = cnt_ff[0];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd15) begin
               cnt_in = 7'd0;
               state_in = sha256_pkg::ST_CLEAR;
            end
         end
         sha256_pkg::ST_CLEAR: begin
            blk_we = 1'b1;
            blk_wa = cnt_ff[3:0];
            blk_wd = 32'd0;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd15) begin
               cnt_in = 7'd0;
               unique case (after_ff)
                  sha256_pkg::NX_PAD: state_in = sha256_pkg::ST_PAD;
                  sha256_pkg::NX_LEN: state_in = sha256_pkg::ST_LEN;
                  sha256_pkg::NX_OUT: state_in = sha256_pkg::ST_OUT;
                  default:            state_in = sha256_pkg::ST_IDLE;
               endcase
            end
         end
         sha256_pkg::ST_OUT: begin
            // even cnt: read word; odd cnt: present it
            chn_ra = cnt_ff[3:1];
            rsp.valid = cnt_ff[0];
            if (!cnt_ff[0] || rsp.ready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'd15) begin
                  cnt_in = 7'd0;
                  state_in = sha256_pkg::ST_INIT;
               end
            end
         end
         default: state_in = sha256_pkg::ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_INIT;
         after_ff <= sha256_pkg::NX_DONE;
         fill_ff  <= 6'd0;
         bytes_ff <= 61'd0;
         cnt_ff   <= 7'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
      byte_ff <= byte_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
   end

endmodule
`default_nettype wire

FILE: test/sha256_tb_if.sv
// ----------------------------------------------------------------------------
// Testbench interface file
// The stream interfaces come from the RTL; this file holds the test-side
// stall limit used by the testbench watchdog.
// ----------------------------------------------------------------------------
package sha256_tb_pkg;
   localparam int STALL_LIMIT  = 20000;
endpackage

FILE: test/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches accepted requests, runs its own hash predictor and compares
// every delivered digest word against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_word_index,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_last_word,
   output int          error_count,
   output int          pending_words,
   output int          digests_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] word;
      logic        final_word;
   } digest_word_type;

   logic [31:0]     hash_state [8];
   logic [31:0]     msg_block [16];
   logic [5:0]      block_fill;
   logic [60:0]     byte_total;
   digest_word_type digest_queue [$];

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + sched[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
   endtask

   task automatic clear_message();
      for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::INIT_HASH[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      block_fill = '0;
      byte_total = '0;
   endtask

   task automatic pack_byte(input logic [7:0] b);
      msg_block[block_fill[5:2]][8*(3 - block_fill[1:0]) +: 8] = b;
      block_fill = block_fill + 6'd1;
   endtask

   task automatic absorb_request(input logic [7:0] b, input logic bv, input logic lst);
      logic [63:0] bit_len;
      digest_word_type dw;
      if (bv) begin
         pack_byte(b);
         byte_total = byte_total + 61'd1;
         if (block_fill == 0) compress_block();
      end
      if (lst) begin
         pack_byte(sha256_pkg::PAD_BYTE);
         if (block_fill == 0 || block_fill > sha256_pkg::LEN_LIMIT) compress_block();
         bit_len = {byte_total, 3'b000};
         msg_block[14] = bit_len[63:32];
         msg_block[15] = bit_len[31:0];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            dw.index = 3'(i);
            dw.word = hash_state[i];
            dw.final_word = (i == 7);
            digest_queue.push_back(dw);
         end
         clear_message();
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      digests_seen = 0;
      clear_message();
   end

   assign pending_words = digest_queue.size();

   always @(posedge clock) begin
      digest_word_type exp_word;
      if (!reset) begin
         if (req_valid && req_ready) absorb_request(req_data_byte, req_byte_valid, req_last);
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               report("unexpected word", rsp_digest_word, '0);
            end else begin
               exp_word = digest_queue.pop_front();
               if (rsp_word_index !== exp_word.index)
                  report("word_index", 32'(rsp_word_index), 32'(exp_word.index));
               if (rsp_digest_word !== exp_word.word)
                  report("digest_word", rsp_digest_word, exp_word.word);
               if (rsp_last_word !== exp_word.final_word)
                  report("last_word", 32'(rsp_last_word), 32'(exp_word.final_word));
               if (exp_word.final_word) digests_seen++;
            end
         end
      end
   end
endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher testbench
// Sends directed and random messages in bursts with a stalling receiver;
// the checker predicts each digest and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count, pending_words, digests_seen;
   int   idle_cycles = 0;
   int   requests_sent = 0;
   int   stall_mode = 0;
   logic [7:0] byte_seen_or = '0, byte_seen_and = '1;

   sha256_req_if req_if ();
   sha256_rsp_if rsp_if ();

   sha256_byte_stream_hasher u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   sha256_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_data_byte   (req_if.data_byte),
      .req_byte_valid  (req_if.byte_valid),
      .req_last        (req_if.last),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_word_index  (rsp_if.word_index),
      .rsp_digest_word (rsp_if.digest_word),
      .rsp_last_word   (rsp_if.last_word),
      .error_count     (error_count),
      .pending_words   (pending_words),
      .digests_seen    (digests_seen)
   );

   always #1 clock = ~clock;

   // receiver stall pattern: switch between always-ready, sparse and random
   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= int'($urandom_range(0, 2));
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_if.ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > sha256_tb_pkg::STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   int burst_left = 0;

   // hold the request until accepted; insert random gaps between bursts
   task automatic send_request(input logic [7:0] b, input logic bv, input logic lst);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.byte_valid <= bv;
      req_if.last <= lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (bv) begin
         byte_seen_or |= b;
         byte_seen_and &= b;
      end
      requests_sent++;
   endtask

   task automatic send_message(input int len, input int pattern);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (pattern)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         // the final byte either carries last itself or a bare last follows
         if (i == len - 1 && pattern != 3) send_request(b, 1'b1, 1'b1);
         else send_request(b, 1'b1, 1'b0);
         if ($urandom_range(0, 15) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      if (len == 0 || pattern == 3) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      int len;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.byte_valid <= 1'b0;
      req_if.last <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: empty message, ignored no-op, single bytes of extremes
      send_message(0, 2);
      send_request(8'hA5, 1'b0, 1'b0);
      send_message(1, 0);
      send_message(1, 1);
      send_message(1, 3);
      // pause until every expected word has come
      drain_results();
      // boundary lengths: pad fits, pad overflows, block fills exactly
      send_message(55, 2);
      send_message(56, 2);
      send_message(64, 3);
      drain_results();
      // random messages, mostly short, a few spanning several blocks
      while (requests_sent < 250) begin
         len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 140))
                                           : int'($urandom_range(0, 20));
         send_message(len, $urandom_range(0, 9) < 8 ? 2 : int'($urandom_range(0, 3)));
         if ($urandom_range(0, 19) == 0) drain_results();
      end
      drain_results();
      $display("sent %0d requests, checked %0d digests (empty, pad-boundary and multi-block)",
               requests_sent, digests_seen);
      $display("byte bits seen high %b, seen low %b", byte_seen_or, ~byte_seen_and);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
